@@ design/brqa_pkg.sv @@
package brqa_pkg;

    // Array geometry
    localparam int MAX_LEN     = 65536;
    localparam int BLOCK_SIZE  = 256;
    localparam int BLOCK_COUNT = (MAX_LEN + BLOCK_SIZE - 1) / BLOCK_SIZE;

    // Widths
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int BLK_W   = $clog2(BLOCK_SIZE);
    localparam int BIDX_W  = IDX_W - BLK_W;
    localparam int FIELD_W = 16;
    localparam int VAL_W   = 32;
    localparam int EXT_W   = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;

    // Function codes of an input beat
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    // Datapath operations
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ELEM  = 2'd1,
        OP_TAG   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    // One command from the sequencer to the datapath
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [IDX_W-1:0]  elem_addr;
        logic [BIDX_W-1:0] tag_addr;
        logic [VAL_W-1:0]  value;
        logic              zero;
    } t_cmd;

endpackage

@@ design/brqa_seq.sv @@
module brqa_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_func,
    input  logic [brqa_pkg::FIELD_W-1:0]  i_left_index,
    input  logic [brqa_pkg::FIELD_W-1:0]  i_right_index,
    input  logic [brqa_pkg::VAL_W-1:0]    i_operand_value,
    output logic                          o_busy,
    output brqa_pkg::t_cmd                o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_ELEM  = 6'b000100,
        S_TAG   = 6'b001000,
        S_QUERY = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [brqa_pkg::IDX_W-1:0]      r_cur, n_cur;
    logic [brqa_pkg::IDX_W-1:0]      r_end, n_end;
    logic [brqa_pkg::IDX_W-1:0]      r_hi, n_hi;
    logic [brqa_pkg::BIDX_W-1:0]     r_bl, n_bl;
    logic [brqa_pkg::BIDX_W-1:0]     r_br, n_br;
    logic [brqa_pkg::BIDX_W-1:0]     r_tcur, n_tcur;
    logic                            r_split, n_split;
    logic                            r_second, n_second;
    logic                            r_zero, n_zero;
    logic [brqa_pkg::VAL_W-1:0]      r_value, n_value;

    // Input indices, extended for range checks
    logic [brqa_pkg::EXT_W-1:0]      left_ext, right_ext;
    logic [brqa_pkg::IDX_W-1:0]      lo_idx, hi_idx;
    logic [brqa_pkg::BIDX_W-1:0]     lo_blk, hi_blk;
    logic                            left_oob;
    logic [brqa_pkg::BIDX_W:0]       blk_gap;
    logic [brqa_pkg::BIDX_W:0]       tcur_next;

    assign left_ext  = brqa_pkg::EXT_W'(i_left_index);
    assign right_ext = brqa_pkg::EXT_W'(i_right_index);
    assign left_oob  = left_ext >= brqa_pkg::EXT_W'(brqa_pkg::MAX_LEN);
    assign lo_idx    = brqa_pkg::IDX_W'(left_ext);
    // Clamp the range end to the last element
    assign hi_idx    = (right_ext >= brqa_pkg::EXT_W'(brqa_pkg::MAX_LEN)) ?
                       brqa_pkg::IDX_W'(brqa_pkg::MAX_LEN - 1) :
                       brqa_pkg::IDX_W'(right_ext);
    assign lo_blk    = lo_idx[brqa_pkg::IDX_W-1:brqa_pkg::BLK_W];
    assign hi_blk    = hi_idx[brqa_pkg::IDX_W-1:brqa_pkg::BLK_W];
    assign blk_gap   = {1'b0, r_br} - {1'b0, r_bl};
    assign tcur_next = {1'b0, r_tcur} + 1'b1;

    assign o_busy = (r_state != S_IDLE);

    // Sequencer: issues load and query commands; a range add walks the partial blocks, then the whole-block tags
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_end    = r_end;
        n_hi     = r_hi;
        n_bl     = r_bl;
        n_br     = r_br;
        n_tcur   = r_tcur;
        n_split  = r_split;
        n_second = r_second;
        n_zero   = r_zero;
        n_value  = r_value;

        o_cmd.valid     = 1'b0;
        o_cmd.op        = brqa_pkg::OP_WRITE;
        o_cmd.elem_addr = r_cur;
        o_cmd.tag_addr  = r_tcur;
        o_cmd.value     = r_value;
        o_cmd.zero      = r_zero;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value = i_operand_value;
                    n_cur   = lo_idx;
                    unique case (brqa_pkg::t_func'(i_func))
                        brqa_pkg::FUNC_LOAD: begin
                            if (!left_oob) begin
                                n_state = S_LOAD;
                            end
                        end
                        brqa_pkg::FUNC_ADD: begin
                            if (!left_oob && (lo_idx <= hi_idx)) begin
                                n_hi     = hi_idx;
                                n_bl     = lo_blk;
                                n_br     = hi_blk;
                                n_split  = (lo_blk != hi_blk);
                                n_second = 1'b0;
                                n_end    = (lo_blk == hi_blk) ? hi_idx :
                                           {lo_blk, {brqa_pkg::BLK_W{1'b1}}};
                                n_state  = S_ELEM;
                            end
                        end
                        brqa_pkg::FUNC_QUERY: begin
                            n_zero  = left_oob;
                            n_tcur  = lo_blk;
                            n_state = S_QUERY;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = brqa_pkg::OP_WRITE;
                n_state     = S_IDLE;
            end
            S_ELEM: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = brqa_pkg::OP_ELEM;
                n_cur       = r_cur + 1'b1;
                if (r_cur == r_end) begin
                    if (r_split && !r_second) begin
                        // second partial block
                        n_second = 1'b1;
                        n_cur    = {r_br, {brqa_pkg::BLK_W{1'b0}}};
                        n_end    = r_hi;
                    end else if (r_split && (blk_gap > 1)) begin
                        n_tcur  = r_bl + 1'b1;
                        n_state = S_TAG;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_TAG: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = brqa_pkg::OP_TAG;
                n_tcur      = brqa_pkg::BIDX_W'(tcur_next);
                if (tcur_next == {1'b0, r_br}) begin
                    n_state = S_DRAIN;
                end
            end
            S_QUERY: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = brqa_pkg::OP_QUERY;
                n_state     = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_end    <= n_end;
        r_hi     <= n_hi;
        r_bl     <= n_bl;
        r_br     <= n_br;
        r_tcur   <= n_tcur;
        r_split  <= n_split;
        r_second <= n_second;
        r_zero   <= n_zero;
        r_value  <= n_value;
    end

endmodule

@@ design/brqa_dp.sv @@
module brqa_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  brqa_pkg::t_cmd              i_cmd,
    output logic                        o_result_valid,
    output logic [brqa_pkg::VAL_W-1:0]  o_result
);

    // Element and tag stores
    logic [brqa_pkg::VAL_W-1:0]      r_elem_mem [brqa_pkg::MAX_LEN];
    logic [brqa_pkg::VAL_W-1:0]      r_tag_mem  [brqa_pkg::BLOCK_COUNT];
    logic [brqa_pkg::BLOCK_COUNT-1:0] r_tag_vld;

    logic [brqa_pkg::VAL_W-1:0]      r_elem_rd;
    logic [brqa_pkg::VAL_W-1:0]      r_tag_rd;
    logic                            r_tag_rd_vld;

    // Stage between read and write back
    logic                            r_st_valid;
    brqa_pkg::t_op                   r_st_op;
    logic [brqa_pkg::IDX_W-1:0]      r_st_eaddr;
    logic [brqa_pkg::BIDX_W-1:0]     r_st_taddr;
    logic [brqa_pkg::VAL_W-1:0]      r_st_value;
    logic                            r_st_zero;

    logic [brqa_pkg::VAL_W-1:0]      r_out;
    logic                            r_out_valid;

    logic [brqa_pkg::VAL_W-1:0]      tag_eff;
    logic [brqa_pkg::VAL_W-1:0]      add_a, add_b, add_sum;
    logic                            elem_we, tag_we;
    logic [brqa_pkg::IDX_W-1:0]      elem_wa;
    logic [brqa_pkg::VAL_W-1:0]      elem_wd;

    // A tag never written reads as zero
    assign tag_eff = r_tag_rd_vld ? r_tag_rd : '0;

    // Shared adder: element or tag plus addend, or element plus tag
    assign add_a   = (r_st_op == brqa_pkg::OP_TAG) ? tag_eff : r_elem_rd;
    assign add_b   = (r_st_op == brqa_pkg::OP_QUERY) ? tag_eff : r_st_value;
    assign add_sum = add_a + add_b;

    // Write-back selection
    assign elem_we = (i_cmd.valid && (i_cmd.op == brqa_pkg::OP_WRITE)) ||
                     (r_st_valid && (r_st_op == brqa_pkg::OP_ELEM));
    assign elem_wa = (r_st_valid && (r_st_op == brqa_pkg::OP_ELEM)) ?
                     r_st_eaddr : i_cmd.elem_addr;
    assign elem_wd = (r_st_valid && (r_st_op == brqa_pkg::OP_ELEM)) ?
                     add_sum : i_cmd.value;
    assign tag_we  = r_st_valid && (r_st_op == brqa_pkg::OP_TAG);

    // Element store port
    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            r_elem_mem[elem_wa] <= elem_wd;
        end
        if (i_cmd.valid) begin
            r_elem_rd <= r_elem_mem[i_cmd.elem_addr];
        end
    end

    // Tag store port
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[r_st_taddr] <= add_sum;
        end
        if (i_cmd.valid) begin
            r_tag_rd <= r_tag_mem[i_cmd.tag_addr];
        end
    end

    // Tag valid bits and tag read qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld    <= '0;
            r_tag_rd_vld <= 1'b0;
        end else begin
            if (tag_we) begin
                r_tag_vld[r_st_taddr] <= 1'b1;
            end
            if (i_cmd.valid) begin
                r_tag_rd_vld <= r_tag_vld[i_cmd.tag_addr];
            end
        end
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st_valid  <= i_cmd.valid && (i_cmd.op != brqa_pkg::OP_WRITE);
            r_out_valid <= r_st_valid && (r_st_op == brqa_pkg::OP_QUERY);
        end
    end

    // Stage payload and result register
    always_ff @(posedge i_clk) begin
        r_st_op    <= i_cmd.op;
        r_st_eaddr <= i_cmd.elem_addr;
        r_st_taddr <= i_cmd.tag_addr;
        r_st_value <= i_cmd.value;
        r_st_zero  <= i_cmd.zero;
        r_out      <= r_st_zero ? '0 : add_sum;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

@@ design/block_range_add_point_query_core.sv @@
// Channel   Ports                                              Handshake
// input     i_func i_left_index i_right_index i_operand_value  start & !busy
// result    o_query_value                                      o_result_valid, one cycle
//
// Query: the result is strobed in the first cycle with busy low.
// Range add: one element or tag per cycle, read from its store and written back
// through the one adder in the following cycle.
// Reset (synchronous, active low) clears the sequencer and all tag valid bits at
// once; the element store is not cleared. The receiver cannot stall results.
module block_range_add_point_query_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_func,
    input  logic [brqa_pkg::FIELD_W-1:0]        i_left_index,
    input  logic [brqa_pkg::FIELD_W-1:0]        i_right_index,
    input  logic signed [brqa_pkg::VAL_W-1:0]   i_operand_value,
    output logic                                o_result_valid,
    output logic signed [brqa_pkg::VAL_W-1:0]   o_query_value
);

    brqa_pkg::t_cmd              cmd;
    logic                        seq_busy;
    logic [brqa_pkg::VAL_W-1:0]  result;

    // Sequencer
    brqa_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_func          (i_func),
        .i_left_index    (i_left_index),
        .i_right_index   (i_right_index),
        .i_operand_value (i_operand_value),
        .o_busy          (seq_busy),
        .o_cmd           (cmd)
    );

    // Stores and shared adder
    brqa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_result_valid (o_result_valid),
        .o_result       (result)
    );

    assign busy          = seq_busy;
    assign o_query_value = result;

endmodule
